FILE: sv/mbet_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared types, constants and helpers for the escape-time pixel engine.
// ----------------------------------------------------------------------------
package mbet_pkg;

    localparam int MAX_ITERATIONS = 255;
    localparam int IMAGE_SIZE     = 128;
    localparam int FRAC_BITS      = 28;
    localparam int COUNT_SCALE    = 256 / MAX_ITERATIONS;

    localparam logic [7:0]  COUNT_CAP    = 8'd255;
    localparam logic [35:0] ESCAPE_LIMIT = 36'd1 << (FRAC_BITS + 2);

    localparam logic signed [39:0] SAT_HI = 40'sh00_7FFF_FFFF;
    localparam logic signed [39:0] SAT_LO = 40'shFF_8000_0000;

    // configuration register indexes
    localparam logic [1:0] CFG_ORIGIN_RE = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_IM = 2'd1;
    localparam logic [1:0] CFG_STEP_RE   = 2'd2;
    localparam logic [1:0] CFG_STEP_IM   = 2'd3;

    localparam logic signed [31:0] ORIGIN_RE_RST = -32'sd671088640;
    localparam logic signed [31:0] ORIGIN_IM_RST = -32'sd536870912;
    localparam logic [30:0]        STEP_RE_RST   = 31'd7340032;
    localparam logic [30:0]        STEP_IM_RST   = 31'd8388608;

    // datapath operation codes
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_CRE   = 3'd1;
    localparam logic [2:0] OP_CIM   = 3'd2;
    localparam logic [2:0] OP_SQRE  = 3'd3;
    localparam logic [2:0] OP_SQIM  = 3'd4;
    localparam logic [2:0] OP_CROSS = 3'd5;
    localparam logic [2:0] OP_UPD   = 3'd6;

    typedef struct packed {
        logic       load;
        logic [2:0] op;
    } cmd_t;

    typedef struct packed {
        logic escape;
    } stat_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] count;
        logic       in_set;
    } res_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
            r = SAT_HI[31:0];
        else if (v < SAT_LO)
            r = SAT_LO[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [6:0] clamp_coord(input logic [6:0] v);
        logic [12:0] ext;
        logic [6:0]  r;
        ext = {6'd0, v};
        if (ext >= 13'(IMAGE_SIZE))
            r = 7'(IMAGE_SIZE - 1);
        else
            r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/mandelbrot_escape_time_pixel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time iteration of z = z*z + c for one pixel in Q4.28 fixed point.
// ----------------------------------------------------------------------------
// one pixel at a time: a new transaction is taken only after the previous result
// has gone to the output register, which waits while that output is stalled;
// each update costs three products on the single shared 32x32 multiplier
// reset: configuration returns to the default view, controller idles, output valid clears
module mandelbrot_escape_time_pixel
    import mbet_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [6:0]  column,
    input  logic [6:0]  row,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  escape_count,
    output logic        inside_res
);

    logic signed [31:0] origin_re_reg;
    logic signed [31:0] origin_im_reg;
    logic [30:0]        step_re_reg;
    logic [30:0]        step_im_reg;
    logic               out_valid_reg;
    logic [7:0]         count_reg;
    logic               inside_reg;
    logic               out_busy;
    cmd_t               cmd;
    stat_t              status;
    res_t               res;

    assign cfg_ready = 1'b1;
    assign out_busy  = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_re_reg <= ORIGIN_RE_RST;
            origin_im_reg <= ORIGIN_IM_RST;
            step_re_reg   <= STEP_RE_RST;
            step_im_reg   <= STEP_IM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ORIGIN_RE: origin_re_reg <= cfg_data;
                CFG_ORIGIN_IM: origin_im_reg <= cfg_data;
                CFG_STEP_RE:   step_re_reg   <= cfg_data[30:0];
                CFG_STEP_IM:   step_im_reg   <= cfg_data[30:0];
                default:
                begin
                end
            endcase
        end
    end

    mbet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_busy (out_busy),
        .status   (status),
        .cmd      (cmd),
        .res      (res)
    );

    mbet_dp u_dp (
        .clk       (clk),
        .column    (column),
        .row       (row),
        .origin_re (origin_re_reg),
        .origin_im (origin_im_reg),
        .step_re   (step_re_reg),
        .step_im   (step_im_reg),
        .cmd       (cmd),
        .status    (status)
    );

    // output register decouples the result from the next pixel's work
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            count_reg  <= res.count;
            inside_reg <= res.in_set;
        end
    end

    assign out_valid    = out_valid_reg;
    assign escape_count = count_reg;
    assign inside_res   = inside_reg;

    a_inside_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && inside_res) |-> (escape_count == COUNT_CAP))
        else $error("inside result without capped count");

    a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second transaction taken while a pixel is in flight");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !out_busy)
        else $error("result loaded over a stalled output");

endmodule
`default_nettype wire

FILE: sv/mbet_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbet_dp
// Datapath: c and z registers around one shared 32x32 unsigned multiplier.
// ----------------------------------------------------------------------------
module mbet_dp
    import mbet_pkg::*;
(
    input  logic               clk,
    input  logic [6:0]         column,
    input  logic [6:0]         row,
    input  logic signed [31:0] origin_re,
    input  logic signed [31:0] origin_im,
    input  logic [30:0]        step_re,
    input  logic [30:0]        step_im,
    input  cmd_t               cmd,
    output stat_t              status
);

    logic [6:0]         col_reg;
    logic [6:0]         row_reg;
    logic [63:0]        p_reg;
    logic signed [31:0] c_re_reg;
    logic signed [31:0] c_im_reg;
    logic signed [31:0] z_re_reg;
    logic signed [31:0] z_im_reg;
    logic [34:0]        re2_reg;
    logic               neg_reg;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        product;
    logic [34:0]        im2;
    logic [35:0]        mag_sum;
    logic signed [39:0] cre_sum;
    logic signed [39:0] cim_sum;
    logic signed [39:0] zre_sum;
    logic               cross_round;
    logic [36:0]        cross_mag;
    logic signed [39:0] cross_val;
    logic signed [39:0] zim_sum;

    // operand select for the shared multiplier
    always_comb
    begin
        case (cmd.op)
            OP_CRE:
            begin
                mul_a = {1'b0, step_re};
                mul_b = {25'd0, col_reg};
            end
            OP_CIM:
            begin
                mul_a = {1'b0, step_im};
                mul_b = {25'd0, row_reg};
            end
            OP_SQRE, OP_UPD:
            begin
                mul_a = mag32(z_re_reg);
                mul_b = mag32(z_re_reg);
            end
            OP_SQIM:
            begin
                mul_a = mag32(z_im_reg);
                mul_b = mag32(z_im_reg);
            end
            OP_CROSS:
            begin
                mul_a = mag32(z_re_reg);
                mul_b = mag32(z_im_reg);
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    assign cre_sum = 40'(origin_re) + $signed({1'b0, p_reg[38:0]});
    assign cim_sum = 40'(origin_im) + $signed({1'b0, p_reg[38:0]});

    // squares are at most 2^62, so bits 62:28 hold the rescaled value
    assign im2     = p_reg[62:28];
    assign mag_sum = {1'b0, re2_reg} + {1'b0, im2};
    assign zre_sum = $signed({5'd0, re2_reg}) - $signed({5'd0, im2}) + 40'(c_re_reg);

    // cross term is floor(2*re*im), rounding away from zero on the magnitude when negative
    assign cross_round = neg_reg & (|p_reg[26:0]);
    assign cross_mag   = {1'b0, p_reg[62:27]} + {36'd0, cross_round};
    assign cross_val   = neg_reg ? -$signed({3'd0, cross_mag}) : $signed({3'd0, cross_mag});
    assign zim_sum     = cross_val + 40'(c_im_reg);

    assign status.escape = (mag_sum > ESCAPE_LIMIT);

    always_ff @(posedge clk)
    begin
        p_reg <= product;
        if (cmd.load)
        begin
            col_reg <= clamp_coord(column);
            row_reg <= clamp_coord(row);
        end
        case (cmd.op)
            OP_CIM:
            begin
                c_re_reg <= sat32(cre_sum);
                z_re_reg <= sat32(cre_sum);
            end
            OP_SQRE:
            begin
                c_im_reg <= sat32(cim_sum);
                z_im_reg <= sat32(cim_sum);
            end
            OP_SQIM:
            begin
                re2_reg <= p_reg[62:28];
            end
            OP_CROSS:
            begin
                neg_reg  <= z_re_reg[31] ^ z_im_reg[31];
                z_re_reg <= sat32(zre_sum);
            end
            OP_UPD:
            begin
                z_im_reg <= sat32(zim_sum);
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/mbet_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbet_ctrl
// Controller: sequences the datapath operations and counts iterations.
// ----------------------------------------------------------------------------
module mbet_ctrl
    import mbet_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  out_busy,
    input  stat_t status,
    output cmd_t  cmd,
    output res_t  res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CRE   = 3'd1;
    localparam logic [2:0] ST_CIM   = 3'd2;
    localparam logic [2:0] ST_SQ0   = 3'd3;
    localparam logic [2:0] ST_SQIM  = 3'd4;
    localparam logic [2:0] ST_CROSS = 3'd5;
    localparam logic [2:0] ST_UPD   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [7:0]  cnt_reg;
    logic [7:0]  cnt_next;
    logic        inside_reg;
    logic        inside_next;
    logic [7:0]  cnt_inc;
    logic [15:0] scaled;

    assign cnt_inc  = cnt_reg + 8'd1;
    assign scaled   = 16'(cnt_reg) * 16'(COUNT_SCALE);
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        inside_next = inside_reg;
        cmd.load    = 1'b0;
        cmd.op      = OP_NONE;
        res.valid   = 1'b0;
        res.in_set  = inside_reg;
        res.count   = (inside_reg || (scaled > 16'(COUNT_CAP))) ? COUNT_CAP : scaled[7:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = 8'd0;
                    state_next = ST_CRE;
                end
            end
            ST_CRE:
            begin
                cmd.op     = OP_CRE;
                state_next = ST_CIM;
            end
            ST_CIM:
            begin
                cmd.op     = OP_CIM;
                state_next = ST_SQ0;
            end
            ST_SQ0:
            begin
                cmd.op     = OP_SQRE;
                state_next = ST_SQIM;
            end
            ST_SQIM:
            begin
                cmd.op     = OP_SQIM;
                state_next = ST_CROSS;
            end
            ST_CROSS:
            begin
                cmd.op = OP_CROSS;
                if (status.escape)
                begin
                    inside_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.op   = OP_UPD;
                cnt_next = cnt_inc;
                if (cnt_inc == 8'(MAX_ITERATIONS))
                begin
                    inside_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_SQIM;
                end
            end
            ST_DONE:
            begin
                if (!out_busy)
                begin
                    res.valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= 8'd0;
            inside_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            inside_reg <= inside_next;
        end
    end

endmodule
`default_nettype wire

FILE: bench/mandelbrot_escape_time_pixel_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_tb
// Self-checking bench for the escape-time pixel engine. Pixels are sent
// through the input channel under a series of view settings and every result
// is compared against an escape-time calculation done in the bench, in the
// same Q4.28 arithmetic. Both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_tb;
    import mbet_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct {
        logic [7:0] count;
        logic       in_set;
    } escape_result_t;

    localparam int     HOLD_CYCLES   = 400;
    localparam int     QUIET_LIMIT   = 8000;
    localparam int     RANDOM_PHASES = 10;
    localparam int     PHASE_ITEMS   = 163;
    localparam int     TAIL_CYCLES   = 40;
    localparam u64_t   ESCAPE_SQ     = u64_t'(4) << FRAC_BITS;
    localparam longint Q_MAX         = 64'sd2147483647;
    localparam longint Q_MIN         = -64'sd2147483648;

    class escape_scoreboard;
        logic signed [31:0] origin_re;
        logic signed [31:0] origin_im;
        logic [30:0]        step_re;
        logic [30:0]        step_im;
        escape_result_t     pending_escapes[$];
        int                 errors;

        function new();
            origin_re = ORIGIN_RE_RST;
            origin_im = ORIGIN_IM_RST;
            step_re   = STEP_RE_RST;
            step_im   = STEP_IM_RST;
            errors    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_ORIGIN_RE: origin_re = data;
                CFG_ORIGIN_IM: origin_im = data;
                CFG_STEP_RE:   step_re   = data[30:0];
                CFG_STEP_IM:   step_im   = data[30:0];
                default:       ;
            endcase
        endfunction

        function longint clip_q428(longint v);
            if (v > Q_MAX)
                return Q_MAX;
            if (v < Q_MIN)
                return Q_MIN;
            return v;
        endfunction

        function u64_t magnitude(longint v);
            return (v < 0) ? u64_t'(-v) : u64_t'(v);
        endfunction

        function escape_result_t escape_time(logic [6:0] px_col, logic [6:0] px_row);
            escape_result_t r;
            longint         col;
            longint         line;
            longint         c_re;
            longint         c_im;
            longint         z_re;
            longint         z_im;
            longint         cross_term;
            u64_t           re2;
            u64_t           im2;
            u64_t           prod;
            int             n;
            bit             escaped;
            col  = (px_col >= IMAGE_SIZE) ? longint'(IMAGE_SIZE - 1) : longint'(px_col);
            line = (px_row >= IMAGE_SIZE) ? longint'(IMAGE_SIZE - 1) : longint'(px_row);
            c_re = clip_q428(longint'(origin_re) + longint'(step_re) * col);
            c_im = clip_q428(longint'(origin_im) + longint'(step_im) * line);
            z_re = c_re;
            z_im = c_im;
            n = 0;
            escaped = 1'b0;
            while (n < MAX_ITERATIONS && !escaped)
            begin
                re2 = (magnitude(z_re) * magnitude(z_re)) >> FRAC_BITS;
                im2 = (magnitude(z_im) * magnitude(z_im)) >> FRAC_BITS;
                if (re2 + im2 > ESCAPE_SQ)
                    escaped = 1'b1;
                else
                begin
                    // cross term is 2*re*im, floored toward minus infinity
                    prod = magnitude(z_re) * magnitude(z_im);
                    if ((z_re < 0) != (z_im < 0))
                        cross_term = -longint'((prod + ((u64_t'(1) << (FRAC_BITS - 1)) - 1))
                                               >> (FRAC_BITS - 1));
                    else
                        cross_term = longint'(prod >> (FRAC_BITS - 1));
                    z_im = clip_q428(cross_term + c_im);
                    z_re = clip_q428(longint'(re2) - longint'(im2) + c_re);
                    n++;
                end
            end
            if (!escaped)
            begin
                r.count  = COUNT_CAP;
                r.in_set = 1'b1;
            end
            else
            begin
                r.count  = (n * COUNT_SCALE > 255) ? COUNT_CAP : 8'(n * COUNT_SCALE);
                r.in_set = 1'b0;
            end
            return r;
        endfunction

        function void note_pixel(logic [6:0] px_col, logic [6:0] px_row);
            pending_escapes.push_back(escape_time(px_col, px_row));
        endfunction

        function void check_result(logic [7:0] count, logic in_set);
            escape_result_t want;
            if (pending_escapes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual count %0d inside %0b",
                         $time, count, in_set);
                errors++;
            end
            else
            begin
                want = pending_escapes.pop_front();
                if (count !== want.count)
                begin
                    $display("%0t: escape_count expected %0d actual %0d",
                             $time, want.count, count);
                    errors++;
                end
                if (in_set !== want.in_set)
                begin
                    $display("%0t: inside_res expected %0b actual %0b",
                             $time, want.in_set, in_set);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_escapes.size();
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = CFG_ORIGIN_RE;
    logic [31:0] cfg_data     = 32'd0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [6:0]  column       = 7'd0;
    logic [6:0]  row          = 7'd0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [7:0]  escape_count;
    logic        inside_res;

    escape_scoreboard sb;
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit hold_wanted  = 1'b0;
    int quiet_cycles = 0;

    mandelbrot_escape_time_pixel uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .column       (column),
        .row          (row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .escape_count (escape_count),
        .inside_res   (inside_res)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [6:0] pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 7'd0;
        if (sel == 1)
            return 7'd127;
        return 7'($urandom_range(0, 127));
    endfunction

    // leaves valid high after the transaction so back-to-back pixels need no toggle
    task automatic send_pixel(input logic [6:0] px_col, input logic [6:0] px_row);
        if ($urandom_range(1, 100) <= tx_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        column   <= px_col;
        row      <= px_row;
        do @(posedge clk); while (in_stall);
        sb.note_pixel(px_col, px_row);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic write_view(input logic [31:0] o_re, input logic [31:0] o_im,
                              input logic [31:0] s_re, input logic [31:0] s_im);
        write_reg(CFG_ORIGIN_RE, o_re);
        write_reg(CFG_ORIGIN_IM, o_im);
        write_reg(CFG_STEP_RE, s_re);
        write_reg(CFG_STEP_IM, s_im);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // result side: check, then decide next cycle's stall
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result(escape_count, inside_res);
            if (hold_wanted)
            begin
                hold_wanted = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(1, 100) <= rx_stall_pct)
            begin
                stall_left = $urandom_range(0, 11);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("mandelbrot_escape_time_pixel_tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [31:0] view_ore;
        logic [31:0] view_oim;
        logic [31:0] view_sre;
        logic [31:0] view_sim;
        int          p;
        int          i;

        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default view after reset: corners, a point next to c = 0, and three more
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        send_pixel(7'd0, 7'd0);
        send_pixel(7'd127, 7'd127);
        send_pixel(7'd0, 7'd127);
        send_pixel(7'd127, 7'd0);
        send_pixel(7'd91, 7'd64);
        send_pixel(7'd45, 7'd64);
        send_pixel(7'd73, 7'd41);
        send_pixel(7'd127, 7'd64);
        drain();

        // c pushed past the top of the range, saturates
        write_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_pixel(7'd0, 7'd0);
        send_pixel(7'd127, 7'd127);
        send_pixel(7'd1, 7'd0);
        drain();

        // most negative corner, escapes before the first update
        write_view(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
        send_pixel(7'd0, 7'd0);
        send_pixel(7'd127, 7'd127);
        drain();

        // c = 0 never escapes: full iteration count
        write_view(32'd0, 32'd0, 32'd0, 32'd0);
        send_pixel(7'd0, 7'd0);
        send_pixel(7'd127, 7'd127);
        drain();

        // c = -2 sits exactly on the escape radius
        write_view(32'hE000_0000, 32'd0, 32'h0040_0000, 32'h0040_0000);
        send_pixel(7'd0, 7'd0);
        send_pixel(7'd1, 7'd0);
        send_pixel(7'd0, 7'd1);
        send_pixel(7'd64, 7'd0);
        send_pixel(7'd127, 7'd127);
        drain();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == RANDOM_PHASES - 1)
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            else
            begin
                tx_gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            end
            case (p % 4)
                0:
                begin
                    // jittered default view
                    view_ore = 32'(-671088640 + $urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
                    view_oim = 32'(-536870912 + $urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
                    view_sre = $urandom_range(32'h0020_0000, 32'h0080_0000);
                    view_sim = $urandom_range(32'h0020_0000, 32'h0080_0000);
                end
                1:
                begin
                    // zoom somewhere around the set boundary
                    view_ore = 32'(-536870912 + $urandom_range(0, 32'h2800_0000));
                    view_oim = 32'(-268435456 + $urandom_range(0, 32'h2000_0000));
                    view_sre = $urandom_range(32'h0001_0000, 32'h0020_0000);
                    view_sim = $urandom_range(32'h0001_0000, 32'h0020_0000);
                end
                2:
                begin
                    view_ore = $urandom;
                    view_oim = $urandom;
                    view_sre = $urandom;
                    view_sim = $urandom;
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: view_ore = 32'h8000_0000;
                        1: view_ore = 32'h7FFF_FFFF;
                        2: view_ore = 32'd0;
                        default: view_ore = $urandom;
                    endcase
                    case ($urandom_range(0, 3))
                        0: view_oim = 32'h8000_0000;
                        1: view_oim = 32'h7FFF_FFFF;
                        2: view_oim = 32'd0;
                        default: view_oim = $urandom;
                    endcase
                    case ($urandom_range(0, 2))
                        0: view_sre = 32'd0;
                        1: view_sre = 32'hFFFF_FFFF;
                        default: view_sre = $urandom_range(1, 32'h0040_0000);
                    endcase
                    case ($urandom_range(0, 2))
                        0: view_sim = 32'd0;
                        1: view_sim = 32'hFFFF_FFFF;
                        default: view_sim = $urandom_range(1, 32'h0040_0000);
                    endcase
                end
            endcase
            write_view(view_ore, view_oim, view_sre, view_sim);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // long receiver hold-off during the random-view phase so the input backs up
                if (p == 2 && i == 10)
                    hold_wanted = 1'b1;
                send_pixel(pick_coord(), pick_coord());
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("mandelbrot_escape_time_pixel_tb OK");
        else
            $display("mandelbrot_escape_time_pixel_tb NOT OK");
        $finish;
    end

endmodule
